// ===== hw/rtl/pcr_pkg.sv =====
// Shared widths, types and helper functions for the particle contact resolver.
package pcr_pkg;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int imin(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    localparam int CW            = 16;
    localparam int FB            = 8;
    localparam int NF            = CW - 2;
    localparam int VW            = 3 * CW;
    localparam int RST_W         = 9;
    localparam int RS_SHIFT      = 8;
    localparam int TOT_W         = CW + 1;
    localparam int DPROD_W       = 2 * CW + 1;
    localparam int SEP_SUM_W     = DPROD_W + 2;
    localparam int SEP_W         = SEP_SUM_W - NF;
    localparam int NPROD_W       = SEP_W + RST_W;
    localparam int NEWSEP_W      = NPROD_W - RS_SHIFT;
    localparam int DELTA_W       = imax(NEWSEP_W, SEP_W) + 1;
    localparam int PN_W          = 2 * CW - 1;
    localparam int DIV_W         = imax(DELTA_W + FB, PN_W);
    localparam int GA_RAW_W      = DIV_W + CW;
    localparam int GA_W          = GA_RAW_W - FB;
    localparam int GAIN_LIM_BITS = 40;
    localparam int GCL_W         = imin(GA_W, GAIN_LIM_BITS + 1);
    localparam int GAX_W         = imax(GA_W, GAIN_LIM_BITS + 1);
    localparam int VPW           = GCL_W + 1 + CW;
    localparam int PPW           = 2 * CW;
    localparam int SAT_W         = imax(VPW, PPW) - NF + 1;
    localparam int MOVE_W        = CW - 1;

    localparam logic [GAX_W-1:0] GAIN_LIMIT = GAX_W'(64'd1 << GAIN_LIM_BITS);
    localparam logic signed [SAT_W-1:0] COMP_MAX = SAT_W'((1 << (CW - 1)) - 1);
    localparam logic signed [SAT_W-1:0] COMP_MIN = SAT_W'(-(1 << (CW - 1)));

    // Operands that ride alongside the divider.
    typedef struct packed {
        logic [VW-1:0] va;
        logic [VW-1:0] vb;
        logic [VW-1:0] pa;
        logic [VW-1:0] pb;
        logic [VW-1:0] nrm;
        logic [CW-1:0] ia;
        logic [CW-1:0] ib;
        logic [CW-1:0] pen;
        logic          vel_ch;
        logic          pos_ch;
    } side_t;

    typedef struct packed {
        logic [VW-1:0] nva;
        logic [VW-1:0] nvb;
        logic [VW-1:0] npa;
        logic [VW-1:0] npb;
        logic          vel_ch;
        logic          pos_ch;
        logic          sat;
    } result_t;

    typedef struct packed {
        logic [CW-1:0] v;
        logic          clip;
    } clip_t;

    function automatic clip_t clip_comp(input logic signed [SAT_W-1:0] x);
        clip_t r;
        if (x > COMP_MAX) begin
            r.v    = COMP_MAX[CW-1:0];
            r.clip = 1'b1;
        end else if (x < COMP_MIN) begin
            r.v    = COMP_MIN[CW-1:0];
            r.clip = 1'b1;
        end else begin
            r.v    = x[CW-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/pcr_front.sv =====
// Front stages: separating velocity, step conditions and divider operands.
module pcr_front import pcr_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [VW-1:0]    velocity_a,
    input  logic [VW-1:0]    velocity_b,
    input  logic [VW-1:0]    position_a,
    input  logic [VW-1:0]    position_b,
    input  logic [VW-1:0]    contact_normal,
    input  logic [CW-1:0]    inv_mass_a,
    input  logic [CW-1:0]    inv_mass_b,
    input  logic [CW-1:0]    penetration,
    input  logic [RST_W-1:0] restitution,
    output logic             out_valid,
    output side_t            out_side,
    output logic [DIV_W-1:0] num_vel,
    output logic [DIV_W-1:0] num_pos,
    output logic [TOT_W-1:0] den
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;

    side_t                     s1_side_reg, s2_side_reg, s3_side_reg;
    logic signed [DPROD_W-1:0] s1_dprod_reg [3];
    logic [TOT_W-1:0]          s1_total_reg, s2_total_reg, s3_total_reg;
    logic                      s1_penpos_reg;
    logic [PN_W-1:0]           s1_pn_reg, s2_pn_reg;
    logic [SEP_W-1:0]          s2_negsep_reg;
    logic [DIV_W-1:0]          s3_numv_reg, s3_nump_reg;

    // Stage 1 logic.
    side_t                     side_in;
    logic signed [CW:0]        diff [3];
    logic signed [DPROD_W-1:0] dprod [3];
    logic [TOT_W-1:0]          total;
    logic                      pen_pos;
    logic [PN_W-1:0]           pn;

    always_comb begin
        side_in        = '0;
        side_in.va     = velocity_a;
        side_in.vb     = velocity_b;
        side_in.pa     = position_a;
        side_in.pb     = position_b;
        side_in.nrm    = contact_normal;
        side_in.ia     = inv_mass_a;
        side_in.ib     = inv_mass_b;
        side_in.pen    = penetration;
        for (int i = 0; i < 3; i++) begin
            diff[i]  = $signed({velocity_a[i*CW + CW - 1], velocity_a[i*CW +: CW]})
                     - $signed({velocity_b[i*CW + CW - 1], velocity_b[i*CW +: CW]});
            dprod[i] = DPROD_W'(diff[i] * $signed(contact_normal[i*CW +: CW]));
        end
        total   = TOT_W'(inv_mass_a) + TOT_W'(inv_mass_b);
        pen_pos = !penetration[CW-1] && (penetration != '0);
        pn      = PN_W'(penetration[CW-2:0]) * PN_W'(inv_mass_a);
    end

    // Stage 2 logic.
    logic signed [SEP_SUM_W-1:0] sep_sum;
    logic signed [SEP_SUM_W-1:0] sep_full;
    logic [SEP_W-1:0]            sep;
    logic                        sep_le0;
    side_t                       side2;

    always_comb begin
        sep_sum = SEP_SUM_W'(s1_dprod_reg[0]) + SEP_SUM_W'(s1_dprod_reg[1])
                + SEP_SUM_W'(s1_dprod_reg[2]);
        sep_full = sep_sum >>> NF;
        sep      = SEP_W'(sep_full);
        sep_le0  = sep[SEP_W-1] || (sep == '0);
        side2        = s1_side_reg;
        side2.vel_ch = sep_le0 && (s1_total_reg != '0);
        side2.pos_ch = s1_penpos_reg && (s1_total_reg != '0);
    end

    // Stage 3 logic: impulse numerator.
    logic [NPROD_W-1:0]  nprod;
    logic [NEWSEP_W-1:0] newsep;
    logic [DELTA_W-1:0]  delta;

    always_comb begin
        nprod  = NPROD_W'(s2_negsep_reg) * NPROD_W'(restitution);
        newsep = NEWSEP_W'(nprod >> RS_SHIFT);
        delta  = DELTA_W'(newsep) + DELTA_W'(s2_negsep_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg   <= side_in;
            s1_dprod_reg  <= dprod;
            s1_total_reg  <= total;
            s1_penpos_reg <= pen_pos;
            s1_pn_reg     <= pn;

            s2_side_reg   <= side2;
            s2_total_reg  <= s1_total_reg;
            s2_pn_reg     <= s1_pn_reg;
            s2_negsep_reg <= SEP_W'(-sep);

            s3_side_reg   <= s2_side_reg;
            s3_total_reg  <= s2_total_reg;
            s3_numv_reg   <= DIV_W'(delta) << FB;
            s3_nump_reg   <= DIV_W'(s2_pn_reg);
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_side  = s3_side_reg;
    assign num_vel   = s3_numv_reg;
    assign num_pos   = s3_nump_reg;
    assign den       = s3_total_reg;

endmodule

// ===== hw/rtl/pcr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module pcr_div import pcr_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic [DIV_W-1:0] num,
    input  logic [TOT_W-1:0] den,
    output logic [DIV_W-1:0] quo,
    output logic [TOT_W-1:0] rem
);

    // The numerator word shifts left; quotient bits fill in from the bottom.
    logic [DIV_W-1:0] num_reg [1:DIV_W];
    logic [TOT_W-1:0] rem_reg [1:DIV_W];
    logic [TOT_W-1:0] den_reg [1:DIV_W];

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [DIV_W-1:0] n_in;
        logic [TOT_W-1:0] r_in;
        logic [TOT_W-1:0] d_in;
        logic [TOT_W:0]   trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign n_in = num;
            assign r_in = '0;
            assign d_in = den;
        end else begin : g_next
            assign n_in = num_reg[k];
            assign r_in = rem_reg[k];
            assign d_in = den_reg[k];
        end

        assign trial = {r_in, n_in[DIV_W-1]};
        assign ge    = trial >= {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k+1] <= {n_in[DIV_W-2:0], ge};
                rem_reg[k+1] <= ge ? TOT_W'(trial - {1'b0, d_in}) : TOT_W'(trial);
                den_reg[k+1] <= d_in;
            end
        end
    end

    assign quo = num_reg[DIV_W];
    assign rem = rem_reg[DIV_W];

endmodule

// ===== hw/rtl/pcr_delay.sv =====
// Delay line that carries valid and operands in step with the dividers.
module pcr_delay import pcr_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  side_t in_side,
    output logic  out_valid,
    output side_t out_side
);

    logic  vld_reg  [1:DIV_W];
    side_t side_reg [1:DIV_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= DIV_W; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en)
        begin
            vld_reg[1] <= in_valid;
            for (int k = 2; k <= DIV_W; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[1] <= in_side;
            for (int k = 2; k <= DIV_W; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[DIV_W];
    assign out_side  = side_reg[DIV_W];

endmodule

// ===== hw/rtl/pcr_back.sv =====
// Back stages: gains, moves along the normal, update and saturation.
module pcr_back import pcr_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  side_t            in_side,
    input  logic [DIV_W-1:0] imp,
    input  logic [DIV_W-1:0] mq,
    input  logic [TOT_W-1:0] mr,
    output logic             out_valid,
    output result_t          out_res
);

    logic b1_valid_reg, b2_valid_reg, b3_valid_reg;

    side_t                 b1_side_reg, b2_side_reg, b3_side_reg;
    logic [GA_RAW_W-1:0]   b1_ga_reg, b1_gb_reg;
    logic [MOVE_W-1:0]     b1_ma_reg, b1_mb_reg, b2_ma_reg, b2_mb_reg;
    logic [GCL_W-1:0]      b2_ga_reg, b2_gb_reg;
    logic signed [VPW-1:0] b3_vpa_reg [3];
    logic signed [VPW-1:0] b3_vpb_reg [3];
    logic signed [PPW-1:0] b3_ppa_reg [3];
    logic signed [PPW-1:0] b3_ppb_reg [3];

    // Stage 1: gains before scaling; B's move follows from A's quotient and remainder.
    logic [MOVE_W-1:0] ma, mb;

    always_comb begin
        ma = MOVE_W'(mq);
        mb = in_side.pen[MOVE_W-1:0] - ma - MOVE_W'(mr != '0);
    end

    // Stage 2: scale and clamp the gains.
    logic [GAX_W-1:0] ga_x, gb_x;

    always_comb begin
        ga_x = GAX_W'(b1_ga_reg >> FB);
        gb_x = GAX_W'(b1_gb_reg >> FB);
        if (ga_x > GAIN_LIMIT)
        begin
            ga_x = GAIN_LIMIT;
        end
        if (gb_x > GAIN_LIMIT)
        begin
            gb_x = GAIN_LIMIT;
        end
    end

    // Stage 3: products with the normal.
    logic signed [VPW-1:0] vpa [3];
    logic signed [VPW-1:0] vpb [3];
    logic signed [PPW-1:0] ppa [3];
    logic signed [PPW-1:0] ppb [3];
    logic signed [CW-1:0]  nc  [3];

    always_comb begin
        for (int i = 0; i < 3; i++)
        begin
            nc[i]  = $signed(b2_side_reg.nrm[i*CW +: CW]);
            vpa[i] = VPW'($signed({1'b0, b2_ga_reg}) * nc[i]);
            vpb[i] = VPW'($signed({1'b0, b2_gb_reg}) * nc[i]);
            ppa[i] = PPW'($signed({1'b0, b2_ma_reg}) * nc[i]);
            ppb[i] = PPW'($signed({1'b0, b2_mb_reg}) * nc[i]);
        end
    end

    // Final update and clamp.
    logic signed [SAT_W-1:0] sum;
    logic signed [SAT_W-1:0] step;
    clip_t                   c;
    result_t                 res;

    always_comb begin
        res        = '0;
        res.vel_ch = b3_side_reg.vel_ch;
        res.pos_ch = b3_side_reg.pos_ch;
        for (int i = 0; i < 3; i++)
        begin
            step = b3_side_reg.vel_ch ? SAT_W'(b3_vpa_reg[i] >>> NF) : '0;
            sum  = SAT_W'($signed(b3_side_reg.va[i*CW +: CW])) + step;
            c    = clip_comp(sum);
            res.nva[i*CW +: CW] = c.v;
            res.sat = res.sat | c.clip;

            step = b3_side_reg.vel_ch ? SAT_W'(b3_vpb_reg[i] >>> NF) : '0;
            sum  = SAT_W'($signed(b3_side_reg.vb[i*CW +: CW])) - step;
            c    = clip_comp(sum);
            res.nvb[i*CW +: CW] = c.v;
            res.sat = res.sat | c.clip;

            step = b3_side_reg.pos_ch ? SAT_W'(b3_ppa_reg[i] >>> NF) : '0;
            sum  = SAT_W'($signed(b3_side_reg.pa[i*CW +: CW])) + step;
            c    = clip_comp(sum);
            res.npa[i*CW +: CW] = c.v;
            res.sat = res.sat | c.clip;

            step = b3_side_reg.pos_ch ? SAT_W'(b3_ppb_reg[i] >>> NF) : '0;
            sum  = SAT_W'($signed(b3_side_reg.pb[i*CW +: CW])) - step;
            c    = clip_comp(sum);
            res.npb[i*CW +: CW] = c.v;
            res.sat = res.sat | c.clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
        end else if (en)
        begin
            b1_valid_reg <= in_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_side_reg <= in_side;
            b1_ga_reg   <= GA_RAW_W'(imp) * GA_RAW_W'(in_side.ia);
            b1_gb_reg   <= GA_RAW_W'(imp) * GA_RAW_W'(in_side.ib);
            b1_ma_reg   <= ma;
            b1_mb_reg   <= mb;

            b2_side_reg <= b1_side_reg;
            b2_ga_reg   <= GCL_W'(ga_x);
            b2_gb_reg   <= GCL_W'(gb_x);
            b2_ma_reg   <= b1_ma_reg;
            b2_mb_reg   <= b1_mb_reg;

            b3_side_reg <= b2_side_reg;
            b3_vpa_reg  <= vpa;
            b3_vpb_reg  <= vpb;
            b3_ppa_reg  <= ppa;
            b3_ppb_reg  <= ppb;
        end
    end

    assign out_valid = b3_valid_reg;
    assign out_res   = res;

endmodule

// ===== hw/rtl/particle_contact_resolver.sv =====
// Particle contact resolver: streams contacts and returns corrected velocities and positions.
//
// Input channel: in_valid/in_stall with one contact per item. Output channel:
// out_valid/out_stall with the updated state of both particles and three flags.
// The restitution register is written through cfg_we/cfg_wdata and must only be
// changed while no contact is in flight.
// One item may enter every clock cycle while in_stall is low. An accepted item
// passes through three front stages, a 31-stage radix-2 divider pair (one
// quotient bit per stage) that forms the impulse and A's position move, three
// back stages, and the output register.
// When the receiver stalls, the result holds in the output register and one more
// item lands in a skid register; only then does in_stall rise and the whole
// pipeline hold, so no item is dropped or repeated.
// Reset clears all valid bits and sets restitution to zero; in_stall is low
// out of reset.
module particle_contact_resolver import pcr_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [RST_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [VW-1:0]    velocity_a,
    input  logic [VW-1:0]    velocity_b,
    input  logic [VW-1:0]    position_a,
    input  logic [VW-1:0]    position_b,
    input  logic [VW-1:0]    contact_normal,
    input  logic [CW-1:0]    inv_mass_a,
    input  logic [CW-1:0]    inv_mass_b,
    input  logic [CW-1:0]    penetration,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [VW-1:0]    new_velocity_a,
    output logic [VW-1:0]    new_velocity_b,
    output logic [VW-1:0]    new_position_a,
    output logic [VW-1:0]    new_position_b,
    output logic             velocity_changed,
    output logic             position_changed,
    output logic             saturated
);

    logic [RST_W-1:0] restitution_reg;
    logic             out_valid_reg, skid_valid_reg;
    result_t          out_data_reg, skid_data_reg;

    logic             adv;
    logic             f_valid, d_valid, b_valid;
    side_t            f_side, d_side;
    logic [DIV_W-1:0] num_vel, num_pos, imp, mq, quo_unused_rem;
    logic [TOT_W-1:0] den, mr, vel_rem;
    result_t          b_res;
    logic             push, pop;

    assign adv = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restitution_reg <= '0;
        end else if (cfg_we)
        begin
            restitution_reg <= cfg_wdata;
        end
    end

    pcr_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (adv),
        .in_valid       (in_valid),
        .velocity_a     (velocity_a),
        .velocity_b     (velocity_b),
        .position_a     (position_a),
        .position_b     (position_b),
        .contact_normal (contact_normal),
        .inv_mass_a     (inv_mass_a),
        .inv_mass_b     (inv_mass_b),
        .penetration    (penetration),
        .restitution    (restitution_reg),
        .out_valid      (f_valid),
        .out_side       (f_side),
        .num_vel        (num_vel),
        .num_pos        (num_pos),
        .den            (den)
    );

    pcr_div u_div_vel (
        .clk (clk),
        .en  (adv),
        .num (num_vel),
        .den (den),
        .quo (imp),
        .rem (vel_rem)
    );

    pcr_div u_div_pos (
        .clk (clk),
        .en  (adv),
        .num (num_pos),
        .den (den),
        .quo (mq),
        .rem (mr)
    );

    pcr_delay u_delay (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .out_valid (d_valid),
        .out_side  (d_side)
    );

    // The impulse remainder is not needed; truncation is the intended rounding.
    assign quo_unused_rem = DIV_W'(vel_rem) & '0;

    pcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d_valid),
        .in_side   (d_side),
        .imp       (imp | quo_unused_rem),
        .mq        (mq),
        .mr        (mr),
        .out_valid (b_valid),
        .out_res   (b_res)
    );

    assign push = b_valid && adv;
    assign pop  = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end else
            begin
                out_valid_reg <= 1'b1;
            end
        end else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= b_res;
            end else
            begin
                out_data_reg <= b_res;
            end
        end
    end

    assign in_stall         = skid_valid_reg;
    assign out_valid        = out_valid_reg;
    assign new_velocity_a   = out_data_reg.nva;
    assign new_velocity_b   = out_data_reg.nvb;
    assign new_position_a   = out_data_reg.npa;
    assign new_position_b   = out_data_reg.npb;
    assign velocity_changed = out_data_reg.vel_ch;
    assign position_changed = out_data_reg.pos_ch;
    assign saturated        = out_data_reg.sat;

endmodule

// ===== hw/rtl/pcr_checker.sv =====
// Port-level checks for the particle contact resolver, bound to the top level.
module pcr_checker import pcr_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [VW-1:0]    new_velocity_a,
    input logic [VW-1:0]    new_position_a,
    input logic             velocity_changed,
    input logic             position_changed,
    input logic             saturated
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_velocity_a)
            && $stable(new_position_a) && $stable(saturated))
        else $error("stalled result changed or dropped");

    // An item that passes through unchanged can never clip.
    a_no_clip_passthru: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !velocity_changed && !position_changed |-> !saturated)
        else $error("saturation flagged on an unchanged contact");

    // The input side only stalls once a result has been held back.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stalled without a held result");

    // With the output empty, the skid stage is empty too.
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output is empty");

endmodule

bind particle_contact_resolver pcr_checker u_pcr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .new_velocity_a   (new_velocity_a),
    .new_position_a   (new_position_a),
    .velocity_changed (velocity_changed),
    .position_changed (position_changed),
    .saturated        (saturated)
);
